// ----- hw/rtl/gwp_pkg.sv -----
// gwp_pkg: shared types, constants and helpers of the g-code word parser
// no dependencies; imported by every gwp module and by the top level

package gwp_pkg;

    localparam int CHAR_W          = 8;
    localparam int VALUE_W         = 32;
    localparam int MAX_WORD_DEF    = 24;
    localparam int FRAC_DIGITS_DEF = 3;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int OUT_DEPTH       = 4;
    localparam int M_MESSAGE_CODE  = 117;

    // result kinds
    localparam logic [2:0] KIND_PARAM   = 3'd0;
    localparam logic [2:0] KIND_COMMAND = 3'd1;
    localparam logic [2:0] KIND_MESSAGE = 3'd2;
    localparam logic [2:0] KIND_UNKNOWN = 3'd3;
    localparam logic [2:0] KIND_EOL     = 3'd4;

    // command letter codes
    localparam logic [3:0] CODE_G = 4'd0;
    localparam logic [3:0] CODE_M = 4'd1;

    // character classes seen by the parser
    typedef enum logic [2:0] {
        CLS_EOL,
        CLS_SPACE,
        CLS_SEMI,
        CLS_DIGIT,
        CLS_POINT,
        CLS_MINUS,
        CLS_PLUS,
        CLS_OTHER
    } cls_t;

    // what a character means when it opens a word
    typedef enum logic [2:0] {
        LK_PARAM,
        LK_G,
        LK_M,
        LK_N,
        LK_UNKNOWN
    } lkind_t;

    // classified character passed from front to back
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [CHAR_W-1:0] upper;
        cls_t              cls;
        logic [3:0]        digit;
        lkind_t            lk;
        logic [3:0]        pcode;
    } item_t;

    // one result transaction
    typedef struct packed {
        logic [2:0]          kind;
        logic [3:0]          code;
        logic [VALUE_W-1:0]  value;
        logic                has_frac;
        logic [CHAR_W-1:0]   mchar;
        logic                bad;
        logic                last;
    } result_t;

    // power of ten for elaboration-time constants
    function automatic logic [63:0] pow10(input int e);
        logic [63:0] r;
        r = 64'd1;
        for (int i = 0; i < 9; i++)
        begin
            if (i < e)
            begin
                r = r * 64'd10;
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/gcode_word_parser_unit.sv -----
// gcode_word_parser_unit: top level of the streaming g-code word parser
// depends on gwp_pkg, gwp_front, gwp_queue and gwp_back

// Streaming G-code word parser. One ASCII character enters per slave
// transaction and the block takes one character every clock cycle as long
// as results are drained. Words are a letter (case-insensitive), an
// optional sign right after it and a decimal number; spaces separate
// words, ';' starts a comment to end of line, and '\n', '\r' or NUL ends
// the line. Each finished word gives one result transaction: a parameter
// word (X Y Z U V W I J D F E T S, with R taken as S), a G/M command or an
// unknown letter; N words give nothing. A line that held words ends with
// an end-of-line result. Values are fixed point in units of
// 10^-FRAC_DIGITS, saturated to 32 bits with the malformed flag set; the
// flag also marks words cut at MAX_WORD characters and stray characters.
// After M117 the next word streams out one message character per result.
// Rate: one character per cycle through the front stage, the queue and the
// word state machine while the result buffer has room; a line end that
// closes a word yields two results, while the master side moves one result
// per cycle, and the four-entry result buffer absorbs the surplus.
// An accepted character passes the front register, the queue and the result
// buffer before its first result appears. tlast marks the last result
// caused by one character.

module gcode_word_parser_unit
    import gwp_pkg::*;
#(
    parameter int MAX_WORD    = MAX_WORD_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // character input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_in[7:0]
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // letter_code[3:0], value[35:4],
                                        // has_fraction[36], message_char[44:37],
                                        // malformed[45], zero fill[47:46]
    output logic [2:0]  m_axis_tuser,   // kind[2:0]
    output logic        m_axis_tlast    // last result of the character
);

    logic    f_valid;
    logic    f_ready;
    item_t   f_item;
    logic    q_valid;
    logic    q_ready;
    item_t   q_item;
    result_t r;

    // classify and register each incoming character
    gwp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_char    (s_axis_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    // decouples classification from the word state machine
    gwp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // word parsing, value scaling and result buffering
    gwp_back #(
        .MAX_WORD    (MAX_WORD),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (r)
    );

    // pack the result transaction onto the master side
    assign m_axis_tdata = {2'b00, r.bad, r.mchar, r.has_frac, r.value, r.code};
    assign m_axis_tuser = r.kind;
    assign m_axis_tlast = r.last;

endmodule

// ----- hw/rtl/gwp_front.sv -----
// gwp_front: input register stage that classifies each character
// depends on gwp_pkg

module gwp_front
    import gwp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_char,
    output logic              out_valid,
    input  logic              out_ready,
    output item_t             out_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;

    function automatic item_t classify(input logic [CHAR_W-1:0] c);
        item_t it;
        it.ch    = c;
        it.upper = (c >= "a" && c <= "z") ? (c - 8'd32) : c;
        it.digit = c[3:0];
        it.pcode = 4'd0;
        it.lk    = LK_UNKNOWN;
        priority if (c == "\n" || c == "\r" || c == 8'd0)
            it.cls = CLS_EOL;
        else if (c == " ")
            it.cls = CLS_SPACE;
        else if (c == ";")
            it.cls = CLS_SEMI;
        else if (c >= "0" && c <= "9")
            it.cls = CLS_DIGIT;
        else if (c == ".")
            it.cls = CLS_POINT;
        else if (c == "-")
            it.cls = CLS_MINUS;
        else if (c == "+")
            it.cls = CLS_PLUS;
        else
            it.cls = CLS_OTHER;
        case (it.upper)
            "X": begin it.lk = LK_PARAM; it.pcode = 4'd0;  end
            "Y": begin it.lk = LK_PARAM; it.pcode = 4'd1;  end
            "Z": begin it.lk = LK_PARAM; it.pcode = 4'd2;  end
            "U": begin it.lk = LK_PARAM; it.pcode = 4'd3;  end
            "V": begin it.lk = LK_PARAM; it.pcode = 4'd4;  end
            "W": begin it.lk = LK_PARAM; it.pcode = 4'd5;  end
            "I": begin it.lk = LK_PARAM; it.pcode = 4'd6;  end
            "J": begin it.lk = LK_PARAM; it.pcode = 4'd7;  end
            "D": begin it.lk = LK_PARAM; it.pcode = 4'd8;  end
            "F": begin it.lk = LK_PARAM; it.pcode = 4'd9;  end
            "E": begin it.lk = LK_PARAM; it.pcode = 4'd10; end
            "T": begin it.lk = LK_PARAM; it.pcode = 4'd11; end
            "S": begin it.lk = LK_PARAM; it.pcode = 4'd12; end
            "R": begin it.lk = LK_PARAM; it.pcode = 4'd12; end
            "G": it.lk = LK_G;
            "M": it.lk = LK_M;
            "N": it.lk = LK_N;
            default: it.lk = LK_UNKNOWN;
        endcase
        return it;
    endfunction

    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (s_ready)
        begin
            valid_next = s_valid;
            if (s_valid)
            begin
                item_next = classify(s_char);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ----- hw/rtl/gwp_queue.sv -----
// gwp_queue: short fifo of classified characters between front and back
// depends on gwp_pkg

module gwp_queue
    import gwp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign in_ready  = (cnt_reg != CNT_W'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- hw/rtl/gwp_back.sv -----
// gwp_back: word state machine, value scaling and result buffer
// depends on gwp_pkg

module gwp_back
    import gwp_pkg::*;
#(
    parameter int MAX_WORD    = MAX_WORD_DEF,
    parameter int FRAC_DIGITS = FRAC_DIGITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    output logic    q_ready,
    input  item_t   q_item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam logic [63:0] SCALE = pow10(FRAC_DIGITS);
    localparam int SCALE_W  = $clog2(SCALE + 1);
    localparam int FRAC_W   = (FRAC_DIGITS > 0) ? $clog2(SCALE) : 1;
    localparam int FDIG_W   = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
    localparam int LEN_W    = $clog2(MAX_WORD + 1);
    localparam int MAG_W    = VALUE_W + SCALE_W;
    localparam int OPTR_W   = $clog2(OUT_DEPTH);
    localparam int OCNT_W   = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_WORD,
        PH_MSG,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  letter;
        lkind_t             lk;
        logic [3:0]         pcode;
        logic               negative;
        logic [VALUE_W-1:0] int_part;
        logic [FRAC_W-1:0]  frac;
        logic [FDIG_W-1:0]  fdig;
        logic               seen_point;
        logic [LEN_W-1:0]   wlen;
        logic               bad;
    } word_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    word_t             w_reg;
    word_t             w_next;
    logic              msg_pend_reg;
    logic              msg_pend_next;
    logic              line_act_reg;
    logic              line_act_next;
    logic [OPTR_W-1:0] wr_ptr_reg;
    logic [OPTR_W-1:0] wr_ptr_next;
    logic [OPTR_W-1:0] rd_ptr_reg;
    logic [OPTR_W-1:0] rd_ptr_next;
    logic [OCNT_W-1:0] cnt_reg;
    logic [OCNT_W-1:0] cnt_next;
    result_t           obuf [OUT_DEPTH];

    logic               take;
    logic               out_pop;
    logic [1:0]         n_res;
    result_t            res0;
    result_t            res1;
    result_t            fin_res;
    result_t            eol_res;
    logic               fin_emit;
    logic               fin_m117;
    logic [MAG_W-1:0]   mag;
    logic [MAG_W-1:0]   limit;
    logic               sat;
    logic [VALUE_W-1:0] mag32;
    logic [VALUE_W+3:0] acc;
    logic [FRAC_W-1:0]  weight;
    logic [FRAC_W+3:0]  fprod;

    // weight of the next fraction digit: 10^(FRAC_DIGITS-1-k)
    function automatic logic [FRAC_W-1:0] frac_weight(input logic [FDIG_W-1:0] k);
        logic [FRAC_W-1:0] r;
        int                e;
        r = FRAC_W'(1);
        e = FRAC_DIGITS - 1 - int'(k);
        for (int i = 0; i < 4; i++)
        begin
            if (i < e)
            begin
                r = FRAC_W'(r * FRAC_W'(10));
            end
        end
        return r;
    endfunction

    assign q_ready   = (cnt_reg <= OCNT_W'(OUT_DEPTH - 2));
    assign take      = q_valid && q_ready;
    assign res_valid = (cnt_reg != '0);
    assign res       = obuf[rd_ptr_reg];
    assign out_pop   = res_valid && res_ready;

    // scaled value and saturation of the open word
    always_comb
    begin
        mag   = MAG_W'(w_reg.int_part) * MAG_W'(SCALE) + MAG_W'(w_reg.frac);
        limit = w_reg.negative ? MAG_W'(33'h080000000) : MAG_W'(33'h07FFFFFFF);
        sat   = (mag > limit);
        mag32 = sat ? limit[VALUE_W-1:0] : mag[VALUE_W-1:0];

        fin_res          = '0;
        fin_res.value    = w_reg.negative ? (VALUE_W'(0) - mag32) : mag32;
        fin_res.has_frac = w_reg.seen_point;
        fin_res.bad      = w_reg.bad || sat;
        unique case (w_reg.lk)
            LK_PARAM:
            begin
                fin_res.kind = KIND_PARAM;
                fin_res.code = w_reg.pcode;
            end
            LK_G:
            begin
                fin_res.kind = KIND_COMMAND;
                fin_res.code = CODE_G;
            end
            LK_M:
            begin
                fin_res.kind = KIND_COMMAND;
                fin_res.code = CODE_M;
            end
            LK_N:
            begin
                fin_res.kind = KIND_PARAM;
            end
            LK_UNKNOWN:
            begin
                fin_res.kind  = KIND_UNKNOWN;
                fin_res.mchar = w_reg.letter;
            end
        endcase
        fin_emit = (w_reg.lk != LK_N);
        fin_m117 = (w_reg.lk == LK_M) && !w_reg.negative
                   && (w_reg.int_part == VALUE_W'(M_MESSAGE_CODE));

        eol_res      = '0;
        eol_res.kind = KIND_EOL;
    end

    // digit accumulation helpers
    always_comb
    begin
        acc    = {w_reg.int_part, 3'b000} + {2'b00, w_reg.int_part, 1'b0}
                 + (VALUE_W+4)'(q_item.digit);
        weight = frac_weight(w_reg.fdig);
        fprod  = {{FRAC_W{1'b0}}, q_item.digit} * {4'b0000, weight};
    end

    always_comb
    begin
        phase_next    = phase_reg;
        w_next        = w_reg;
        msg_pend_next = msg_pend_reg;
        line_act_next = line_act_reg;
        n_res         = 2'd0;
        res0          = fin_res;
        res1          = eol_res;

        if (take)
        begin
            if (q_item.cls == CLS_EOL)
            begin
                // open word first, then end of line if the line had words
                if (phase_reg == PH_WORD && fin_emit)
                begin
                    n_res = line_act_reg ? 2'd2 : 2'd1;
                end
                else if (line_act_reg)
                begin
                    res0  = eol_res;
                    n_res = 2'd1;
                end
                phase_next    = PH_IDLE;
                msg_pend_next = 1'b0;
                line_act_next = 1'b0;
                w_next.wlen   = '0;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                        if (q_item.cls == CLS_SEMI)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if (q_item.cls != CLS_SPACE)
                        begin
                            line_act_next = 1'b1;
                            if (msg_pend_reg)
                            begin
                                msg_pend_next = 1'b0;
                                phase_next    = PH_MSG;
                                w_next.wlen   = LEN_W'(1);
                                res0          = '0;
                                res0.kind     = KIND_MESSAGE;
                                res0.mchar    = q_item.ch;
                                n_res         = 2'd1;
                            end
                            else
                            begin
                                w_next.letter     = q_item.upper;
                                w_next.lk         = q_item.lk;
                                w_next.pcode      = q_item.pcode;
                                w_next.negative   = 1'b0;
                                w_next.int_part   = '0;
                                w_next.frac       = '0;
                                w_next.fdig       = '0;
                                w_next.seen_point = 1'b0;
                                w_next.wlen       = LEN_W'(1);
                                w_next.bad        = 1'b0;
                                phase_next        = PH_WORD;
                            end
                        end
                    end
                    PH_WORD:
                    begin
                        if (q_item.cls == CLS_SPACE || q_item.cls == CLS_SEMI)
                        begin
                            n_res = fin_emit ? 2'd1 : 2'd0;
                            if (fin_m117)
                            begin
                                msg_pend_next = 1'b1;
                            end
                            phase_next = (q_item.cls == CLS_SEMI) ? PH_SKIP : PH_IDLE;
                        end
                        else if (w_reg.wlen >= LEN_W'(MAX_WORD))
                        begin
                            w_next.bad = 1'b1;
                        end
                        else
                        begin
                            w_next.wlen = w_reg.wlen + LEN_W'(1);
                            case (q_item.cls)
                                CLS_DIGIT:
                                begin
                                    if (!w_reg.seen_point)
                                    begin
                                        if (acc[VALUE_W+3:VALUE_W] != 4'd0)
                                        begin
                                            w_next.int_part = '1;
                                            w_next.bad      = 1'b1;
                                        end
                                        else
                                        begin
                                            w_next.int_part = acc[VALUE_W-1:0];
                                        end
                                    end
                                    else if (w_reg.fdig < FDIG_W'(FRAC_DIGITS))
                                    begin
                                        w_next.frac = w_reg.frac + fprod[FRAC_W-1:0];
                                        w_next.fdig = w_reg.fdig + FDIG_W'(1);
                                    end
                                end
                                CLS_POINT:
                                begin
                                    if (!w_reg.seen_point)
                                    begin
                                        w_next.seen_point = 1'b1;
                                    end
                                    else
                                    begin
                                        w_next.bad = 1'b1;
                                    end
                                end
                                CLS_MINUS, CLS_PLUS:
                                begin
                                    // sign only right after the letter
                                    if (w_reg.wlen == LEN_W'(1))
                                    begin
                                        w_next.negative = (q_item.cls == CLS_MINUS);
                                    end
                                    else
                                    begin
                                        w_next.bad = 1'b1;
                                    end
                                end
                                default:
                                begin
                                    w_next.bad = 1'b1;
                                end
                            endcase
                        end
                    end
                    PH_MSG:
                    begin
                        if (q_item.cls == CLS_SPACE || q_item.cls == CLS_SEMI)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else if (w_reg.wlen < LEN_W'(MAX_WORD))
                        begin
                            w_next.wlen = w_reg.wlen + LEN_W'(1);
                            res0        = '0;
                            res0.kind   = KIND_MESSAGE;
                            res0.mchar  = q_item.ch;
                            n_res       = 2'd1;
                        end
                    end
                    PH_SKIP:
                    begin
                        phase_next = PH_SKIP;
                    end
                endcase
            end
        end

        res0.last = (n_res == 2'd1);
        res1.last = 1'b1;

        wr_ptr_next = wr_ptr_reg + OPTR_W'(n_res);
        rd_ptr_next = rd_ptr_reg + OPTR_W'(out_pop);
        cnt_next    = cnt_reg + OCNT_W'(n_res) - OCNT_W'(out_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            w_reg        <= '0;
            msg_pend_reg <= 1'b0;
            line_act_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            w_reg        <= w_next;
            msg_pend_reg <= msg_pend_next;
            line_act_reg <= line_act_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_res != 2'd0)
        begin
            obuf[wr_ptr_reg] <= res0;
        end
        if (n_res == 2'd2)
        begin
            obuf[wr_ptr_reg + OPTR_W'(1)] <= res1;
        end
    end

`ifndef SYNTHESIS
    a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= OCNT_W'(OUT_DEPTH))
        else $error("result buffer count beyond depth");

    a_room_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (cnt_reg + OCNT_W'(2) <= OCNT_W'(OUT_DEPTH)))
        else $error("character taken without room for two results");

    a_msg_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_MSG) |-> !msg_pend_reg)
        else $error("message pending while a message streams");

    a_word_on_line: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WORD || phase_reg == PH_MSG) |-> line_act_reg)
        else $error("open word on a line marked empty");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        w_reg.wlen <= LEN_W'(MAX_WORD))
        else $error("word length beyond cap");
`endif

endmodule

// ----- dv/gwp_checker.sv -----
// gwp_checker: predicts the result stream of the g-code word parser and compares it
// with the master side, transaction by transaction
// depends on gwp_pkg for the result layout, kind and command codes

module gwp_checker
    import gwp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_ready,
    input  logic [7:0]  char_data,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [47:0] res_data,
    input  logic [2:0]  res_kind,
    input  logic        res_last,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_WORD    = MAX_WORD_DEF;
    localparam int FRAC_DIGITS = FRAC_DIGITS_DEF;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_POINT = ".";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_PLUS  = "+";

    typedef enum logic [1:0] {LN_BETWEEN, LN_WORD, LN_MESSAGE, LN_COMMENT} line_state_t;
    typedef enum logic [1:0] {CMDL_NONE, CMDL_G, CMDL_M} cmd_letter_t;

    // parser state as predicted
    line_state_t line_state;
    logic [7:0]  wd_letter;
    logic        wd_neg;
    logic [31:0] int_acc;
    logic [31:0] frac_acc;
    int          frac_cnt;
    logic        saw_point;
    int          wd_len;
    logic        wd_bad;
    cmd_letter_t cmd_letter;
    logic [9:0]  cmd_number;
    logic        msg_armed;
    logic        line_open;

    result_t char_results[$];
    result_t expected_results[$];

    function automatic logic [63:0] ten_pow(input int e);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < e; i++)
        begin
            p = p * 64'd10;
        end
        return p;
    endfunction

    function automatic int letter_param_code(input logic [7:0] l);
        case (l)
            "X": return 0;
            "Y": return 1;
            "Z": return 2;
            "U": return 3;
            "V": return 4;
            "W": return 5;
            "I": return 6;
            "J": return 7;
            "D": return 8;
            "F": return 9;
            "E": return 10;
            "T": return 11;
            "S", "R": return 12;
            default: return -1;
        endcase
    endfunction

    task open_word(input logic [7:0] c);
        wd_letter = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        wd_neg    = 1'b0;
        int_acc   = '0;
        frac_acc  = '0;
        frac_cnt  = 0;
        saw_point = 1'b0;
        wd_len    = 1;
        wd_bad    = 1'b0;
    endtask

    task add_to_word(input logic [7:0] c);
        logic [63:0] grown;
        if (wd_len >= MAX_WORD)
        begin
            wd_bad = 1'b1;
            return;
        end
        wd_len++;
        if (c >= "0" && c <= "9")
        begin
            if (!saw_point)
            begin
                grown = int_acc * 64'd10 + (c - 8'h30);
                if (grown > 64'hFFFF_FFFF)
                begin
                    grown  = 64'hFFFF_FFFF;
                    wd_bad = 1'b1;
                end
                int_acc = grown[31:0];
            end
            else if (frac_cnt < FRAC_DIGITS)
            begin
                frac_acc = frac_acc * 32'd10 + (c - 8'h30);
                frac_cnt++;
            end
        end
        else if (c == CH_POINT && !saw_point)
        begin
            saw_point = 1'b1;
        end
        else if ((c == CH_MINUS || c == CH_PLUS) && wd_len == 2)
        begin
            wd_neg = (c == CH_MINUS);
        end
        else
        begin
            wd_bad = 1'b1;
        end
    endtask

    // closes the open word and queues its result, if it has one
    task close_word();
        result_t     r;
        logic [63:0] mag;
        logic [63:0] limit;
        logic        bad;
        int          pcode;
        mag = int_acc * ten_pow(FRAC_DIGITS) + frac_acc * ten_pow(FRAC_DIGITS - frac_cnt);
        limit = wd_neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        bad = wd_bad;
        if (mag > limit)
        begin
            mag = limit;
            bad = 1'b1;
        end
        r          = '0;
        r.value    = wd_neg ? 32'd0 - mag[31:0] : mag[31:0];
        r.has_frac = saw_point;
        r.bad      = bad;
        if (wd_letter == "N")
        begin
            return;
        end
        if (wd_letter == "G" || wd_letter == "M")
        begin
            cmd_letter = (wd_letter == "G") ? CMDL_G : CMDL_M;
            if (wd_neg)
                cmd_number = '0;
            else if (int_acc > 32'd1023)
                cmd_number = 10'd1023;
            else
                cmd_number = int_acc[9:0];
            if (cmd_letter == CMDL_M && cmd_number == M_MESSAGE_CODE)
                msg_armed = 1'b1;
            r.kind = KIND_COMMAND;
            r.code = (wd_letter == "G") ? CODE_G : CODE_M;
        end
        else
        begin
            pcode = letter_param_code(wd_letter);
            if (pcode >= 0)
            begin
                r.kind = KIND_PARAM;
                r.code = pcode[3:0];
            end
            else
            begin
                r.kind  = KIND_UNKNOWN;
                r.mchar = wd_letter;
            end
        end
        char_results.push_back(r);
    endtask

    // advances the predicted parser by one character, queueing what it emits
    task predict_char(input logic [7:0] c);
        result_t r;
        char_results = {};
        if (c == CH_LF || c == CH_CR || c == CH_NUL)
        begin
            if (line_state == LN_WORD)
                close_word();
            if (line_open)
            begin
                r      = '0;
                r.kind = KIND_EOL;
                char_results.push_back(r);
            end
            line_state = LN_BETWEEN;
            cmd_letter = CMDL_NONE;
            cmd_number = '0;
            msg_armed  = 1'b0;
            line_open  = 1'b0;
            wd_len     = 0;
        end
        else
        begin
            case (line_state)
                LN_BETWEEN:
                begin
                    if (c == CH_SEMI)
                    begin
                        line_state = LN_COMMENT;
                    end
                    else if (c != CH_SPACE)
                    begin
                        line_open = 1'b1;
                        if (msg_armed)
                        begin
                            msg_armed  = 1'b0;
                            line_state = LN_MESSAGE;
                            wd_len     = 1;
                            r          = '0;
                            r.kind     = KIND_MESSAGE;
                            r.mchar    = c;
                            char_results.push_back(r);
                        end
                        else
                        begin
                            open_word(c);
                            line_state = LN_WORD;
                        end
                    end
                end
                LN_WORD:
                begin
                    if (c == CH_SPACE || c == CH_SEMI)
                    begin
                        close_word();
                        line_state = (c == CH_SEMI) ? LN_COMMENT : LN_BETWEEN;
                    end
                    else
                    begin
                        add_to_word(c);
                    end
                end
                LN_MESSAGE:
                begin
                    if (c == CH_SPACE || c == CH_SEMI)
                    begin
                        line_state = LN_COMMENT;
                    end
                    else if (wd_len < MAX_WORD)
                    begin
                        wd_len++;
                        r       = '0;
                        r.kind  = KIND_MESSAGE;
                        r.mchar = c;
                        char_results.push_back(r);
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (char_results.size() > 0)
        begin
            r = char_results.pop_back();
            r.last = 1'b1;
            char_results.push_back(r);
        end
        foreach (char_results[i])
            expected_results.push_back(char_results[i]);
    endtask

    task check_field(input string name, input logic signed [31:0] want,
                     input logic signed [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            line_state = LN_BETWEEN;
            wd_letter  = '0;
            wd_neg     = 1'b0;
            int_acc    = '0;
            frac_acc   = '0;
            frac_cnt   = 0;
            saw_point  = 1'b0;
            wd_len     = 0;
            wd_bad     = 1'b0;
            cmd_letter = CMDL_NONE;
            cmd_number = '0;
            msg_armed  = 1'b0;
            line_open  = 1'b0;
            expected_results = {};
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (char_valid && char_ready)
                predict_char(char_data);
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result transaction, kind %0d", res_kind);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(res_kind));
                    check_field("letter_code", 32'(want.code), 32'(res_data[3:0]));
                    check_field("value", want.value, res_data[35:4]);
                    check_field("has_fraction", 32'(want.has_frac), 32'(res_data[36]));
                    check_field("message_char", 32'(want.mchar), 32'(res_data[44:37]));
                    check_field("malformed", 32'(want.bad), 32'(res_data[45]));
                    check_field("last", 32'(want.last), 32'(res_last));
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// testbench: stimulus and verdict for gcode_word_parser_unit
// depends on gwp_pkg, the parser rtl and gwp_checker, which does all the comparing

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gwp_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 2;
    localparam int RANDOM_CHARS = 1900;
    localparam int HOLD_LEN     = 300;   // long receiver hold-off, in cycles
    localparam int QUIET_LIMIT  = 4000;  // cycles with no transaction on either side
    localparam int TAIL_CYCLES  = 20;    // settle time after the drain, well past the parser latency

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_SEMI  = ";";

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int outstanding;

    // idle percentages of the current phase, and the hold-off request
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;
    int chars_sent = 0;
    int quiet_cycles = 0;

    // idle percentages per phase: none, sender only, receiver only, both
    int tx_phase_pct[4] = '{0, 57, 0, 34};
    int rx_phase_pct[4] = '{0, 0, 57, 34};

    string param_letters = "XYZUVWIJDFETSR";
    // numbers around the saturation and overflow boundaries
    string limit_numbers[9] = '{"2147483.647", "-2147483.648", "2147483.648",
                                "-2147483.649", "4294967295", "4294967296",
                                "99999999999", "-0.0005", "0.9999"};

    always #CLK_HALF clk = ~clk;

    gcode_word_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    gwp_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (s_axis_tvalid),
        .char_ready  (s_axis_tready),
        .char_data   (s_axis_tdata),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_data    (m_axis_tdata),
        .res_kind    (m_axis_tuser),
        .res_last    (m_axis_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // offers one character, with random idle cycles ahead of it; tvalid stays high
    // from one transaction to the next unless a gap is drawn
    task send_char(input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task send_digits(input int n);
        repeat (n)
            send_char(8'("0" + $urandom_range(9)));
    endtask

    // one word: a leading letter (or stray byte), then an optional sign and a number
    task send_word();
        int         pick;
        logic [7:0] lead;
        pick = $urandom_range(99);
        if (pick < 50)
            lead = param_letters[$urandom_range(13)];
        else if (pick < 66)
            lead = $urandom_range(1) ? "G" : "M";
        else if (pick < 72)
            lead = "N";
        else if (pick < 88)
            lead = 8'("A" + $urandom_range(25));
        else
            lead = 8'($urandom_range(255));
        // letters are case-insensitive, so mix in lowercase
        if (lead >= "A" && lead <= "Z" && $urandom_range(2) == 0)
            lead = lead + 8'd32;
        send_char(lead);
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            send_text(limit_numbers[$urandom_range(8)]);
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 25)
                send_char("-");
            else if (pick < 35)
                send_char("+");
            pick = $urandom_range(99);
            if (pick < 70)
                send_digits($urandom_range(4));
            else if (pick < 92)
                send_digits($urandom_range(5, 12));
            else
                send_digits($urandom_range(20, 30));   // can run past the word cap
            if ($urandom_range(99) < 40)
            begin
                send_char(".");
                send_digits($urandom_range(5));
                if ($urandom_range(99) < 3)
                    send_char(".");
            end
            // a stray byte inside the word
            if ($urandom_range(99) < 6)
                send_char(8'($urandom_range(255)));
        end
    endtask

    // m117 followed by a message word of arbitrary non-separator bytes
    task send_message();
        logic [7:0] c;
        send_text($urandom_range(1) ? "M117 " : "m117 ");
        repeat ($urandom_range(1, 30))
        begin
            do
                c = 8'($urandom_range(255));
            while (c == CH_SPACE || c == CH_SEMI || c == CH_LF || c == CH_CR || c == CH_NUL);
            send_char(c);
        end
    endtask

    // one command line: mostly well-formed words, sometimes noise, a message or a comment
    task send_line();
        int words;
        int pick;
        if ($urandom_range(99) < 5)
        begin
            repeat ($urandom_range(1, 20))
                send_char(8'($urandom_range(255)));
            send_char(CH_LF);
            return;
        end
        if ($urandom_range(9) == 0)
            send_char(CH_SPACE);
        words = $urandom_range(6);
        for (int w = 0; w < words; w++)
        begin
            if (w > 0)
                repeat ($urandom_range(1, 2))
                    send_char(CH_SPACE);
            if ($urandom_range(99) < 10)
                send_message();
            else
                send_word();
        end
        if ($urandom_range(99) < 12)
        begin
            send_char(CH_SEMI);
            repeat ($urandom_range(6))
                send_char(8'($urandom_range(32, 126)));
        end
        pick = $urandom_range(3);
        case (pick)
            0: send_char(CH_LF);
            1: send_char(CH_CR);
            2:
            begin
                send_char(CH_CR);
                send_char(CH_LF);
            end
            default: send_char(CH_NUL);
        endcase
    endtask

    // receiver: random stalls, or one long hold-off counted here on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN - 1)
                    @(posedge clk);
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // watchdog: ends the run when no transaction happens for too long
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int phase_end;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed: command and parameter words, repeated spaces, sign and point,
        // message after m117 cut by a comment, cr lf, ignored n word, r as s,
        // a bare letter, an unknown start, nul and the top character code
        send_text("G1  x-1.5\n");
        send_text("M117 Hi;c\r\n");
        send_text("n5 r+2 s ?");
        send_char(CH_NUL);
        send_char(8'hFF);
        send_text("7\n");

        // random lines through the four idling phases; the long hold-off lands in
        // the first one, where the sender never idles and the block backs up
        for (int p = 0; p < 4; p++)
        begin
            tx_idle_pct  = tx_phase_pct[p];
            rx_stall_pct = rx_phase_pct[p];
            if (p == 0)
                hold_req = 1'b1;
            phase_end = chars_sent + RANDOM_CHARS / 4;
            while (chars_sent < phase_end)
                send_line();
        end
        s_axis_tvalid <= 1'b0;

        // let the count take in the last character, drain, then give any stray
        // result time to show up
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
